[sv/rlt_pkg.sv]
// rlt_pkg: shared sizes, status codes, controller states and command struct
// for the recursive lock table; no dependencies
package rlt_pkg;

    localparam int NUM_LOCKS      = 16;
    localparam int THREAD_ID_BITS = 8;
    localparam int COUNT_BITS     = 16;

    // fixed field widths of the request and result words
    localparam int OP_W      = 2;
    localparam int IN_IDX_W  = 4;
    localparam int IN_TID_W  = 8;
    localparam int STATUS_W  = 3;
    localparam int OUT_CNT_W = 16;

    localparam int SLOT_W = $clog2(NUM_LOCKS);

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLOSE   = 2'd1;
    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OTHER_OWNER = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNER   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_COUNT_FULL  = 3'd4;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic update;
    } t_dp_cmd;

endpackage

[sv/rlt_ctrl.sv]
// rlt_ctrl: request sequencer for the recursive lock table
// depends on rlt_pkg
module rlt_ctrl import rlt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    output logic    o_busy,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[sv/rlt_dp.sv]
// rlt_dp: lock slot registers, free-slot search and read-modify-write update
// depends on rlt_pkg
module rlt_dp import rlt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [OP_W-1:0]       i_op,
    input  logic [IN_IDX_W-1:0]   i_lock_index,
    input  logic [IN_TID_W-1:0]   i_thread_id,
    output logic                  o_valid,
    output logic [IN_IDX_W-1:0]   o_result_index,
    output logic [STATUS_W-1:0]   o_status,
    output logic [OUT_CNT_W-1:0]  o_nest_count
);

    // slot state
    logic [NUM_LOCKS-1:0]      r_used;
    logic [NUM_LOCKS-1:0]      r_own_vld;
    logic [THREAD_ID_BITS-1:0] r_owner [NUM_LOCKS];
    logic [COUNT_BITS-1:0]     r_nest  [NUM_LOCKS];

    // captured request
    logic [OP_W-1:0]           r_op;
    logic [IN_IDX_W-1:0]       r_idx;
    logic [THREAD_ID_BITS-1:0] r_tid;

    // lookup results
    logic                      r_free_found;
    logic [SLOT_W-1:0]         r_free_idx;
    logic                      r_in_range;
    logic                      r_rd_vld;
    logic [THREAD_ID_BITS-1:0] r_rd_owner;
    logic [COUNT_BITS-1:0]     r_rd_nest;

    // result word
    logic                      r_valid;
    logic [IN_IDX_W-1:0]       r_res_idx;
    logic [STATUS_W-1:0]       r_res_status;
    logic [OUT_CNT_W-1:0]      r_res_nest;

    logic [SLOT_W-1:0]         slot;
    logic                      free_found;
    logic [SLOT_W-1:0]         free_idx;

    assign slot = SLOT_W'(r_idx);

    // lowest unused slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_idx <= i_lock_index;
            r_tid <= THREAD_ID_BITS'(i_thread_id);
        end
        if (i_cmd.lookup) begin
            r_free_found <= free_found;
            r_free_idx   <= free_idx;
            r_in_range   <= (32'(r_idx) < NUM_LOCKS);
            r_rd_vld     <= r_own_vld[slot];
            r_rd_owner   <= r_owner[slot];
            r_rd_nest    <= r_nest[slot];
        end
    end

    // update step: at most one slot written, one result word formed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_used    <= '0;
            r_own_vld <= '0;
            for (int i = 0; i < NUM_LOCKS; i++) begin
                r_owner[i] <= '0;
                r_nest[i]  <= '0;
            end
        end else begin
            r_valid <= i_cmd.update;
            if (i_cmd.update) begin
                r_res_idx    <= r_idx;
                r_res_status <= ST_DONE;
                r_res_nest   <= OUT_CNT_W'(r_rd_nest);
                if (r_op == OP_ALLOC) begin
                    r_res_nest <= '0;
                    if (r_free_found) begin
                        r_used[r_free_idx]    <= 1'b1;
                        r_own_vld[r_free_idx] <= 1'b0;
                        r_owner[r_free_idx]   <= '0;
                        r_nest[r_free_idx]    <= '0;
                        r_res_idx             <= IN_IDX_W'(r_free_idx);
                    end else begin
                        r_res_idx    <= '0;
                        r_res_status <= ST_NO_SLOT;
                    end
                end else if (!r_in_range) begin
                    r_res_nest <= '0;
                end else begin
                    unique case (r_op)
                        OP_CLOSE: begin
                            r_used[slot] <= 1'b0;
                        end
                        OP_ACQUIRE: begin
                            if (r_rd_vld && r_rd_owner != r_tid) begin
                                r_res_status <= ST_OTHER_OWNER;
                            end else if (r_rd_nest == COUNT_MAX) begin
                                r_res_status <= ST_COUNT_FULL;
                            end else begin
                                r_own_vld[slot] <= 1'b1;
                                r_owner[slot]   <= r_tid;
                                r_nest[slot]    <= r_rd_nest + 1'b1;
                                r_res_nest      <= OUT_CNT_W'(r_rd_nest + 1'b1);
                            end
                        end
                        OP_RELEASE: begin
                            if (!r_rd_vld || r_rd_owner != r_tid) begin
                                r_res_status <= ST_NOT_OWNER;
                            end else begin
                                // count at zero or one leaves the lock free
                                if (r_rd_nest <= COUNT_BITS'(1)) begin
                                    r_own_vld[slot] <= 1'b0;
                                    r_owner[slot]   <= '0;
                                    r_nest[slot]    <= '0;
                                    r_res_nest      <= '0;
                                end else begin
                                    r_nest[slot] <= r_rd_nest - 1'b1;
                                    r_res_nest   <= OUT_CNT_W'(r_rd_nest - 1'b1);
                                end
                            end
                        end
                        default: begin
                            r_res_nest <= '0;
                        end
                    endcase
                end
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_result_index = r_res_idx;
    assign o_status       = r_res_status;
    assign o_nest_count   = r_res_nest;

endmodule

[sv/recursive_lock_table.sv]
// recursive_lock_table: pool of recursive locks, top level
// result strobe o_valid is registered by the update step, which follows the capture
// and lookup steps; a new request is not taken until the current one is through:
// busy is high for the lookup and update states of the slot read-modify-write
// reset: synchronous active-low i_rst_n frees every slot and clears owners/counts
// results are shown for exactly one cycle; the receiver cannot stall
module recursive_lock_table import rlt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request word, taken when start is high and busy is low
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_op,
    input  logic [IN_IDX_W-1:0]   i_lock_index,
    input  logic [IN_TID_W-1:0]   i_thread_id,
    // result word, one cycle wide
    output logic                  o_valid,
    output logic [IN_IDX_W-1:0]   o_result_index,
    output logic [STATUS_W-1:0]   o_status,
    output logic [OUT_CNT_W-1:0]  o_nest_count
);

    // commands from the sequencer to the slot datapath
    t_dp_cmd cmd;

    // sequencer: idle -> lookup (registered slot read and free search)
    // -> update (slot write and result word)
    rlt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    // slot registers and the request arithmetic
    rlt_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_op           (i_op),
        .i_lock_index   (i_lock_index),
        .i_thread_id    (i_thread_id),
        .o_valid        (o_valid),
        .o_result_index (o_result_index),
        .o_status       (o_status),
        .o_nest_count   (o_nest_count)
    );

endmodule
